### sv/sca_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sca_pkg
// Shared constants for the three-class slab allocator: field widths,
// request and status codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
package sca_pkg;

  localparam int unsigned NUM_CLASSES          = 3;
  localparam int unsigned DEF_BLOCKS_PER_CLASS = 32;

  localparam int unsigned SIZE_W   = 12;
  localparam int unsigned CLASS_W  = 2;
  localparam int unsigned INDEX_W  = 5;
  localparam int unsigned STATUS_W = 3;

  typedef logic [SIZE_W-1:0]   size_t;
  typedef logic [CLASS_W-1:0]  class_t;
  typedef logic [INDEX_W-1:0]  index_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam class_t CLASS_NULL = 2'd3;

  localparam status_t ST_GRANTED = 3'd0;
  localparam status_t ST_NOFIT   = 3'd1;
  localparam status_t ST_FREED   = 3'd2;
  localparam status_t ST_DOUBLE  = 3'd3;
  localparam status_t ST_OUTSIDE = 3'd4;

  localparam logic [1:0] REG_SMALL  = 2'd0;
  localparam logic [1:0] REG_MIDDLE = 2'd1;
  localparam logic [1:0] REG_LARGE  = 2'd2;

  localparam size_t SMALL_RESET  = 12'd32;
  localparam size_t MIDDLE_RESET = 12'd64;
  localparam size_t LARGE_RESET  = 12'd128;

endpackage

`default_nettype wire

### sv/three_class_slab_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// three_class_slab_allocator
// Block allocator with three size classes, each a LIFO free list of fixed
// blocks kept in a link memory.
//
//   channel   handshake          words
//   request   start / busy       req_type, request_bytes, release_class,
//                                release_index
//   result    done (strobe)      status, grant_class, grant_index
//   config    cfg_we             cfg_index, cfg_data
//
// Allocate: the size compare tries the classes in turn from the small one,
// then the head of the first class that fits is popped from the link memory,
// with busy high until the grant or the no-fit result. Free: link memory
// read as the request is taken, then push with busy high. A free outside the
// pools is not busy at all. The result word shows on done the cycle after the
// work ends. After reset the link memory is cleared entry by entry with busy
// high. The receiver cannot stall.
// ----------------------------------------------------------------------------
module three_class_slab_allocator #(
  parameter int unsigned BLOCKS_PER_CLASS = sca_pkg::DEF_BLOCKS_PER_CLASS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic             req_type,
  input  wire sca_pkg::size_t   request_bytes,
  input  wire sca_pkg::class_t  release_class,
  input  wire sca_pkg::index_t  release_index,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire sca_pkg::size_t   cfg_data,
  output logic                  done,
  output sca_pkg::status_t      status,
  output sca_pkg::class_t       grant_class,
  output sca_pkg::index_t       grant_index
);

  import sca_pkg::*;

  size_t [NUM_CLASSES-1:0] class_bytes;

  // class size registers; index beyond the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      class_bytes[REG_SMALL]  <= SMALL_RESET;
      class_bytes[REG_MIDDLE] <= MIDDLE_RESET;
      class_bytes[REG_LARGE]  <= LARGE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SMALL:  class_bytes[REG_SMALL]  <= cfg_data;
        REG_MIDDLE: class_bytes[REG_MIDDLE] <= cfg_data;
        REG_LARGE:  class_bytes[REG_LARGE]  <= cfg_data;
        default:    class_bytes <= class_bytes;
      endcase
    end
  end

  sca_ctrl #(
    .BLOCKS_PER_CLASS (BLOCKS_PER_CLASS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .request_bytes (request_bytes),
    .release_class (release_class),
    .release_index (release_index),
    .class_bytes   (class_bytes),
    .done          (done),
    .status        (status),
    .grant_class   (grant_class),
    .grant_index   (grant_index)
  );

endmodule

`default_nettype wire

### sv/sca_link_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sca_link_ram
// Link memory: one entry per block holding its free mark, link-valid bit
// and successor index. One write port, one registered read port.
// ----------------------------------------------------------------------------
module sca_link_ram #(
  parameter int unsigned AW    = 7,
  parameter int unsigned DW    = 7,
  parameter int unsigned DEPTH = 96
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### sv/sca_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sca_ctrl
// Allocator sequencer: clears the link memory after reset, scans the classes
// through one shared size compare, pops or pushes list heads through the
// link memory and registers one result word per request.
// ----------------------------------------------------------------------------
module sca_ctrl #(
  parameter int unsigned BLOCKS_PER_CLASS = sca_pkg::DEF_BLOCKS_PER_CLASS
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire logic                                        start,
  output logic                                             busy,
  input  wire logic                                        req_type,
  input  wire sca_pkg::size_t                              request_bytes,
  input  wire sca_pkg::class_t                             release_class,
  input  wire sca_pkg::index_t                             release_index,
  input  wire sca_pkg::size_t [sca_pkg::NUM_CLASSES-1:0]   class_bytes,
  output logic                                             done,
  output sca_pkg::status_t                                 status,
  output sca_pkg::class_t                                  grant_class,
  output sca_pkg::index_t                                  grant_index
);

  import sca_pkg::*;

  localparam int unsigned IW    = $clog2(BLOCKS_PER_CLASS);
  localparam int unsigned AW    = CLASS_W + IW;
  localparam int unsigned DW    = IW + 2;
  localparam int unsigned DEPTH = NUM_CLASSES << IW;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam class_t LAST_CLASS = CLASS_W'(NUM_CLASSES - 1);

  // entry layout: {free, link_ok, link}
  localparam int unsigned FREE_BIT = IW + 1;
  localparam int unsigned LINK_OK  = IW;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_TAKE  = 5'b01000,
    S_GIVE  = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [AW-1:0] clr_addr;
  class_t        cls;
  size_t         req_bytes;
  class_t        rel_cls;
  logic [IW-1:0] rel_idx;

  logic [IW-1:0] head    [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] head_ok;

  logic          accept;
  logic          rel_outside;
  logic [IW-1:0] rel_idx_in;
  logic          fit;
  logic [IW:0]   clr_succ;
  logic          clr_succ_ok;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;

  assign busy        = (state != S_IDLE);
  assign accept      = start && (state == S_IDLE);
  assign rel_idx_in  = IW'(release_index);
  assign rel_outside = (release_class == CLASS_NULL) ||
                       ({27'd0, release_index} >= 32'(BLOCKS_PER_CLASS));

  // shared size compare, one class per cycle
  assign fit = (req_bytes <= class_bytes[cls]) && head_ok[cls];

  // reset contents of the entry being cleared
  assign clr_succ    = {1'b0, clr_addr[IW-1:0]} + (IW+1)'(1);
  assign clr_succ_ok = ({{(31-IW){1'b0}}, clr_succ} < 32'(BLOCKS_PER_CLASS));

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_addr == LAST_ADDR) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (req_type == REQ_ALLOC)  state_next = S_SCAN;
          else if (!rel_outside)      state_next = S_GIVE;
        end
      end
      S_SCAN: begin
        if (fit)                     state_next = S_TAKE;
        else if (cls == LAST_CLASS)  state_next = S_IDLE;
      end
      S_TAKE:  state_next = S_IDLE;
      S_GIVE:  state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = {rel_cls, rel_idx};
    if (state == S_IDLE) begin
      ram_re    = accept && (req_type == REQ_FREE) && !rel_outside;
      ram_raddr = {release_class, rel_idx_in};
    end else if (state == S_SCAN) begin
      ram_re    = fit;
      ram_raddr = {cls, head[cls]};
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = {1'b1, clr_succ_ok, (clr_succ_ok ? clr_succ[IW-1:0] : IW'(0))};
    unique case (state)
      S_CLEAR: ram_we = 1'b1;
      S_TAKE: begin
        ram_we    = 1'b1;
        ram_waddr = {cls, head[cls]};
        ram_wdata = {1'b0, ram_rdata[LINK_OK:0]};
      end
      S_GIVE: begin
        ram_we    = !ram_rdata[FREE_BIT];
        ram_waddr = {rel_cls, rel_idx};
        ram_wdata = {1'b1, head_ok[rel_cls], head[rel_cls]};
      end
      default: ram_we = 1'b0;
    endcase
  end

  sca_link_ram #(
    .AW    (AW),
    .DW    (DW),
    .DEPTH (DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      cls      <= '0;
      head_ok  <= '1;
      done     <= 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head[c] <= '0;
      end
    end else begin
      state <= state_next;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          done     <= 1'b0;
        end
        S_IDLE: begin
          cls  <= '0;
          done <= accept && (req_type == REQ_FREE) && rel_outside;
        end
        S_SCAN: begin
          // last class missed too: no block fits
          done <= !fit && (cls == LAST_CLASS);
          if (!fit && (cls != LAST_CLASS)) begin
            cls <= cls + CLASS_W'(1);
          end
        end
        S_TAKE: begin
          // pop: head advances to the successor
          head[cls]    <= ram_rdata[IW-1:0];
          head_ok[cls] <= ram_rdata[LINK_OK];
          done         <= 1'b1;
        end
        S_GIVE: begin
          if (!ram_rdata[FREE_BIT]) begin
            head[rel_cls]    <= rel_idx;
            head_ok[rel_cls] <= 1'b1;
          end
          done <= 1'b1;
        end
        default: done <= 1'b0;
      endcase
    end
  end

  // latched request fields and result word
  always_ff @(posedge clk) begin
    if (accept) begin
      req_bytes <= request_bytes;
      rel_cls   <= release_class;
      rel_idx   <= rel_idx_in;
    end
    unique case (state)
      S_IDLE: begin
        status      <= ST_OUTSIDE;
        grant_class <= '0;
        grant_index <= '0;
      end
      S_SCAN: begin
        status      <= ST_NOFIT;
        grant_class <= '0;
        grant_index <= '0;
      end
      S_TAKE: begin
        status      <= ST_GRANTED;
        grant_class <= cls;
        grant_index <= INDEX_W'(head[cls]);
      end
      S_GIVE: begin
        status      <= ram_rdata[FREE_BIT] ? ST_DOUBLE : ST_FREED;
        grant_class <= '0;
        grant_index <= '0;
      end
      default: begin
        status      <= status;
        grant_class <= grant_class;
        grant_index <= grant_index;
      end
    endcase
  end

endmodule

`default_nettype wire

### tb/tb_three_class_slab_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_three_class_slab_allocator
// Self-checking bench for the three-class slab allocator. A short table of
// hand-picked requests opens the run. Allocate and free traffic follows,
// mostly frees of blocks that are really held, so the free lists fill, drain
// and reorder. The size registers change between phases. Every result word is
// compared with the typed-in result of its table row, or else with an in-bench
// model of the three LIFO free lists.
module tb_three_class_slab_allocator;
  import sca_pkg::*;

  localparam int BLOCKS     = DEF_BLOCKS_PER_CLASS;
  localparam int ALL_BLOCKS = NUM_CLASSES * BLOCKS;
  localparam int STALL_MAX  = 1000;
  localparam int PHASES     = 6;
  localparam int PHASE_LEN  = 300;
  localparam int DIR_LEN    = 22;

  localparam class_t CL_SMALL  = 2'd0;
  localparam class_t CL_MIDDLE = 2'd1;
  localparam class_t CL_LARGE  = 2'd2;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    status_t st;
    class_t  cls;
    index_t  idx;
  } alloc_result_t;

  typedef struct packed {
    bit      typed;
    logic    op;
    size_t   bytes;
    class_t  cls;
    index_t  idx;
    status_t w_st;
    class_t  w_cls;
    index_t  w_idx;
  } alloc_row_t;

  localparam alloc_row_t DIR_ROWS [DIR_LEN] = '{
    '{1'b1, REQ_ALLOC, 12'd0,    CL_SMALL,   5'd0,  ST_GRANTED, CL_SMALL,  5'd0},
    '{1'b1, REQ_ALLOC, 12'd32,   CLASS_NULL, 5'd31, ST_GRANTED, CL_SMALL,  5'd1},
    '{1'b1, REQ_ALLOC, 12'd33,   CL_SMALL,   5'd0,  ST_GRANTED, CL_MIDDLE, 5'd0},
    '{1'b1, REQ_ALLOC, 12'd64,   CL_SMALL,   5'd0,  ST_GRANTED, CL_MIDDLE, 5'd1},
    '{1'b1, REQ_ALLOC, 12'd65,   CL_SMALL,   5'd0,  ST_GRANTED, CL_LARGE,  5'd0},
    '{1'b1, REQ_ALLOC, 12'd128,  CL_SMALL,   5'd0,  ST_GRANTED, CL_LARGE,  5'd1},
    '{1'b1, REQ_ALLOC, 12'd129,  CL_SMALL,   5'd0,  ST_NOFIT,   CL_SMALL,  5'd0},
    '{1'b1, REQ_ALLOC, 12'd4095, CLASS_NULL, 5'd31, ST_NOFIT,   CL_SMALL,  5'd0},
    '{1'b1, REQ_FREE,  12'd4095, CL_SMALL,   5'd1,  ST_FREED,   CL_SMALL,  5'd0},
    '{1'b1, REQ_FREE,  12'd0,    CL_SMALL,   5'd1,  ST_DOUBLE,  CL_SMALL,  5'd0},
    '{1'b1, REQ_FREE,  12'd0,    CL_SMALL,   5'd5,  ST_DOUBLE,  CL_SMALL,  5'd0},
    '{1'b1, REQ_FREE,  12'd0,    CLASS_NULL, 5'd0,  ST_OUTSIDE, CL_SMALL,  5'd0},
    '{1'b1, REQ_FREE,  12'd4095, CLASS_NULL, 5'd31, ST_OUTSIDE, CL_SMALL,  5'd0},
    '{1'b0, REQ_ALLOC, 12'd1,    CL_SMALL,   5'd0,  ST_GRANTED, CL_SMALL,  5'd0},
    '{1'b1, REQ_FREE,  12'd0,    CL_LARGE,   5'd0,  ST_FREED,   CL_SMALL,  5'd0},
    '{1'b1, REQ_FREE,  12'd0,    CL_LARGE,   5'd31, ST_DOUBLE,  CL_SMALL,  5'd0},
    '{1'b0, REQ_ALLOC, 12'd100,  CL_SMALL,   5'd0,  ST_GRANTED, CL_SMALL,  5'd0},
    '{1'b1, REQ_FREE,  12'd0,    CL_MIDDLE,  5'd0,  ST_FREED,   CL_SMALL,  5'd0},
    '{1'b1, REQ_FREE,  12'd0,    CL_MIDDLE,  5'd1,  ST_FREED,   CL_SMALL,  5'd0},
    '{1'b0, REQ_ALLOC, 12'd40,   CL_SMALL,   5'd0,  ST_GRANTED, CL_SMALL,  5'd0},
    '{1'b0, REQ_ALLOC, 12'd64,   CL_SMALL,   5'd0,  ST_GRANTED, CL_SMALL,  5'd0},
    '{1'b0, REQ_ALLOC, 12'd64,   CL_SMALL,   5'd0,  ST_GRANTED, CL_SMALL,  5'd0}
  };

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  logic    req_type = REQ_ALLOC;
  size_t   request_bytes = '0;
  class_t  release_class = '0;
  index_t  release_index = '0;
  logic    cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_SMALL;
  size_t   cfg_data = '0;
  logic    done;
  status_t status;
  class_t  grant_class;
  index_t  grant_index;

  // row being offered, and its typed-in result where it has one
  bit            row_typed = 1'b0;
  alloc_result_t row_want = '0;

  // model of the free lists
  size_t  class_limit [NUM_CLASSES];
  index_t head_idx    [NUM_CLASSES];
  bit     head_ok     [NUM_CLASSES];
  index_t link_next   [ALL_BLOCKS];
  bit     link_ok     [ALL_BLOCKS];
  bit     blk_free    [ALL_BLOCKS];

  alloc_result_t results_due [$];
  int mismatches   = 0;
  int results_seen = 0;
  int stall_cycles = 0;

  three_class_slab_allocator #(
    .BLOCKS_PER_CLASS(BLOCKS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .request_bytes(request_bytes),
    .release_class(release_class),
    .release_index(release_index),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done),
    .status(status),
    .grant_class(grant_class),
    .grant_index(grant_index)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic alloc_result_t allocator_step(input logic op, input size_t bytes,
                                                   input class_t cls, input index_t idx);
    alloc_result_t res;
    int slot;
    res = '{st: ST_NOFIT, cls: '0, idx: '0};
    if (op == REQ_ALLOC) begin
      // first class that covers the size and still has a block wins
      for (int c = 0; c < NUM_CLASSES; c++) begin
        if (res.st == ST_NOFIT && bytes <= class_limit[c] && head_ok[c]) begin
          slot = c * BLOCKS + head_idx[c];
          res = '{st: ST_GRANTED, cls: class_t'(c), idx: head_idx[c]};
          head_idx[c] = link_next[slot];
          head_ok[c] = link_ok[slot];
          blk_free[slot] = 1'b0;
        end
      end
    end else if (cls >= NUM_CLASSES || idx >= BLOCKS) begin
      res.st = ST_OUTSIDE;
    end else begin
      slot = cls * BLOCKS + idx;
      if (blk_free[slot]) begin
        res.st = ST_DOUBLE;
      end else begin
        link_next[slot] = head_idx[cls];
        link_ok[slot] = head_ok[cls];
        head_idx[cls] = idx;
        head_ok[cls] = 1'b1;
        blk_free[slot] = 1'b1;
        res.st = ST_FREED;
      end
    end
    return res;
  endfunction

  // Mostly allocates and frees of held blocks; some frees are noise.
  function automatic alloc_row_t make_request(input int alloc_pct);
    alloc_row_t r;
    int pick;
    int first;
    int slot;
    int c;
    bit found;
    r = '0;
    r.op = REQ_ALLOC;
    r.bytes = size_t'($urandom);
    r.cls = class_t'($urandom);
    r.idx = index_t'($urandom);
    pick = $urandom_range(99);
    if (pick >= 92) begin
      r.op = REQ_FREE;
    end else if (pick >= alloc_pct) begin
      first = $urandom_range(ALL_BLOCKS - 1);
      found = 1'b0;
      for (int k = 0; k < ALL_BLOCKS; k++) begin
        slot = (first + k) % ALL_BLOCKS;
        if (!found && !blk_free[slot]) begin
          found = 1'b1;
          r.op = REQ_FREE;
          r.cls = class_t'(slot / BLOCKS);
          r.idx = index_t'(slot % BLOCKS);
        end
      end
    end
    if (r.op == REQ_ALLOC) begin
      // aim at the edges of a class limit
      c = $urandom_range(NUM_CLASSES - 1);
      case ($urandom_range(5))
        0: r.bytes = '0;
        1: r.bytes = class_limit[c];
        2: r.bytes = class_limit[c] + 1'b1;
        3: r.bytes = class_limit[c] - 1'b1;
        4: r.bytes = size_t'($urandom);
        default: r.bytes = '1;
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    $display("MISMATCH word %0d %s: got %0d, expected %0d at %0t",
             results_seen, what, got_v, want_v, $realtime);
    mismatches++;
  endtask

  // Call at a falling edge; returns at the rising edge that takes the word.
  task automatic offer(input alloc_row_t r);
    start = 1'b1;
    req_type = r.op;
    request_bytes = r.bytes;
    release_class = r.cls;
    release_index = r.idx;
    row_typed = r.typed;
    row_want = '{st: r.w_st, cls: r.w_cls, idx: r.w_idx};
    do @(posedge clk); while (busy);
  endtask

  task automatic set_limits(input size_t s, input size_t m, input size_t l);
    logic [1:0] ids [4];
    size_t vals [4];
    ids = '{REG_SMALL, REG_MIDDLE, REG_LARGE, REG_UNUSED};
    vals = '{s, m, l, size_t'($urandom)};
    for (int k = 0; k < 4; k++) begin
      @(negedge clk);
      cfg_we = 1'b1;
      cfg_index = ids[k];
      cfg_data = vals[k];
    end
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  always @(posedge clk) begin : monitor
    alloc_result_t want;
    alloc_result_t calc;
    if (!rst) begin
      if (done) begin
        if (results_due.size() == 0) begin
          report_mismatch("result with nothing pending, status", status, -1);
        end else begin
          want = results_due.pop_front();
          if (status !== want.st) report_mismatch("status", status, want.st);
          if (grant_class !== want.cls) report_mismatch("grant_class", grant_class, want.cls);
          if (grant_index !== want.idx) report_mismatch("grant_index", grant_index, want.idx);
        end
        results_seen++;
      end
      if (cfg_we && cfg_index < NUM_CLASSES) class_limit[cfg_index] = cfg_data;
      if (start && !busy) begin
        calc = allocator_step(req_type, request_bytes, release_class, release_index);
        results_due.push_back(row_typed ? row_want : calc);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((start && !busy) || done || cfg_we) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_MAX) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int idle_pct;
    int alloc_pct;
    alloc_row_t r;
    class_limit[0] = SMALL_RESET;
    class_limit[1] = MIDDLE_RESET;
    class_limit[2] = LARGE_RESET;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      head_idx[c] = '0;
      head_ok[c] = 1'b1;
      for (int i = 0; i < BLOCKS; i++) begin
        link_next[c * BLOCKS + i] = index_t'((i + 1) % BLOCKS);
        link_ok[c * BLOCKS + i] = (i + 1 < BLOCKS);
        blk_free[c * BLOCKS + i] = 1'b1;
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int n = 0; n < DIR_LEN; n++) begin
      @(negedge clk);
      offer(DIR_ROWS[n]);
    end

    alloc_pct = 60;
    for (int p = 0; p < PHASES; p++) begin
      @(negedge clk);
      start = 1'b0;
      row_typed = 1'b0;
      // drain before touching the size registers
      while (results_due.size() != 0 || busy) @(posedge clk);
      case (p)
        0: idle_pct = 0;
        1: begin
          idle_pct = 50;
          set_limits('1, '1, '1);
        end
        2: begin
          idle_pct = 0;
          set_limits('0, 12'd1, '1);
        end
        3: begin
          idle_pct = 38;
          set_limits('1, 12'd64, 12'd1);
        end
        default: begin
          idle_pct = (p == 4) ? 50 : 38;
          set_limits(size_t'($urandom), size_t'($urandom), size_t'($urandom));
        end
      endcase
      for (int n = 0; n < PHASE_LEN; n++) begin
        // swing between filling and draining the pools
        if (n % 50 == 0) begin
          case ($urandom_range(2))
            0: alloc_pct = 35;
            1: alloc_pct = 60;
            default: alloc_pct = 85;
          endcase
        end
        if ($urandom_range(99) < idle_pct) begin
          repeat ($urandom_range(1, 4)) begin
            @(negedge clk);
            start = 1'b0;
          end
        end
        @(negedge clk);
        r = make_request(alloc_pct);
        offer(r);
      end
    end

    @(negedge clk);
    start = 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### three_class_slab_allocator.f
sv/sca_pkg.sv
sv/sca_link_ram.sv
sv/sca_ctrl.sv
sv/three_class_slab_allocator.sv
tb/tb_three_class_slab_allocator.sv
